// ===== src/gpe_pkg.sv =====
// Shared types, constants and coefficient tables for the geomagnetic polynomial evaluator.
// Used by every module under src; depends on nothing else.
package gpe_pkg;

    localparam int VAL_W      = 14;
    localparam int MODE_W     = 2;
    localparam int OUT_W      = 32;
    localparam int NUM_TERMS  = 31;
    localparam int MAX_DEG    = 4;
    localparam int MONO_W     = 54;   // monomial with 32 fractional bits
    localparam int PWR_W      = 56;   // storage for powers up to the fourth
    localparam int MLO_W      = 27;   // low slice of a monomial in the product split
    localparam int CLO_W      = 32;   // low slice of a coefficient in the product split
    localparam int COEF_INT_W = 16;   // integer and sign bits of a coefficient
    localparam int SUM_GUARD  = 5;    // growth for adding all terms
    localparam int TREE_LEAVES = 32;
    localparam int TREE_DEPTH  = 5;
    localparam int MONO_STG   = 4;
    localparam int TERM_STG   = 3;
    localparam int NUM_STAGES = 1 + MONO_STG + TERM_STG + TREE_DEPTH + 1;

    localparam logic [MODE_W-1:0] MODE_INT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INC = 2'd2;

    localparam logic [VAL_W-1:0] EPOCH_RESET = 14'd1280;
    localparam logic [OUT_W-1:0] OUT_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] OUT_NEG_MAX = 32'h8000_0000;

    localparam longint unsigned DEC_SCALE = 64'd1000000000;

    typedef longint t_coef_set [NUM_TERMS];
    typedef int     t_exp_set  [NUM_TERMS];

    typedef struct packed {
        logic [MONO_STG-1:0]   mono;
        logic [TERM_STG-1:0]   term;
        logic [TREE_DEPTH-1:0] sum;
    } t_stage_en;

    // Coefficients in units of 1e-9.
    localparam t_coef_set COEF_INT = '{
        64'sd24224659636207, 64'sd183996795632, -64'sd35021288453, -64'sd37400009238,
        64'sd3361550943, -64'sd2981093399, 64'sd1003467787, 64'sd8095907512,
        -64'sd1375229967, 64'sd254272806, 64'sd12792782, -64'sd144525770,
        64'sd36415624, -64'sd144366979, 64'sd9647616, 64'sd1985112,
        -64'sd16962150, -64'sd52733877, 64'sd16506825, -64'sd18715,
        64'sd3236118, -64'sd39060, 64'sd779251, 64'sd2273586, 64'sd208493,
        64'sd610764, -64'sd407288, 64'sd612531, 64'sd483826, -64'sd656300,
        64'sd567275 };

    localparam t_coef_set COEF_DEC = '{
        -64'sd13990855321, -64'sd178276825, -64'sd737983503, -64'sd160172410,
        64'sd9037327, 64'sd12042122, 64'sd3918684, 64'sd5522720, 64'sd274259,
        64'sd315750, 64'sd251143, 64'sd150791, 64'sd184300, 64'sd99212,
        64'sd162457, 64'sd47993, -64'sd59871, 64'sd100456, 64'sd2292,
        -64'sd2239, -64'sd5053, -64'sd3229, 64'sd395, -64'sd564, 64'sd1007,
        -64'sd2915, -64'sd630, -64'sd21, 64'sd906, 64'sd163, 64'sd1464 };

    localparam t_coef_set COEF_INC = '{
        -64'sd10006583388, 64'sd1689987698, -64'sd774009842, -64'sd285142172,
        -64'sd19128983, -64'sd9799375, -64'sd9567729, 64'sd11464555,
        -64'sd2605504, -64'sd2096450, 64'sd312138, -64'sd219761, 64'sd242536,
        64'sd496757, -64'sd91865, 64'sd53931, -64'sd405449, 64'sd154646,
        -64'sd8095, 64'sd6410, -64'sd10497, 64'sd4395, 64'sd12169, -64'sd4039,
        64'sd3870, 64'sd4229, 64'sd6854, 64'sd2329, 64'sd852, -64'sd4956,
        64'sd2066 };

    // Exponents of longitude, latitude and epoch for each term.
    localparam t_exp_set EXP_X = '{0,0,1,0,2,1,1,0,0,0,3,2,2,1,1,1,
                                   0,0,0,4,3,3,2,2,2,1,1,0,1,0,0};
    localparam t_exp_set EXP_Y = '{0,1,0,0,0,1,0,2,1,0,0,1,0,2,1,0,
                                   3,2,1,0,1,0,2,1,0,3,2,3,1,4,2};
    localparam t_exp_set EXP_T = '{0,0,0,1,0,0,1,0,1,2,0,0,1,0,1,2,
                                   0,1,2,0,0,1,0,1,2,0,1,1,2,0,2};

    // Signed width that holds any n-th power of a 14-bit operand.
    function automatic int pow_w(input int n);
        return (n == 0) ? 2 : VAL_W * n;
    endfunction

    // Decimal coefficient to fixed point; magnitude rounded half up, sign applied after.
    function automatic logic signed [63:0] coef_fixed(input longint dec, input int frac);
        logic [127:0] mag;
        logic [127:0] quo;
        mag = (dec < 0) ? 128'(-dec) : 128'(dec);
        mag = (mag << frac) + 128'(DEC_SCALE / 2);
        quo = mag / DEC_SCALE;
        return (dec < 0) ? -$signed(quo[63:0]) : $signed(quo[63:0]);
    endfunction

endpackage

// ===== src/geomag_poly_eval.sv =====
// An input transfer reaches m_axis through fourteen register stages; one item per cycle
// while m_axis_tready does not stall the output.
// The stages are the input register, the monomial, term-product and adder-tree stages, and the output register.
// Stalls hold each stage in place; empty stages still fill while the output waits.
// Reset (synchronous, active low) empties the pipeline and sets the epoch to 5.0 years.
// Top level: input register, config register, stage control, rounding and clipping.
// Depends on gpe_pkg, gpe_mono, gpe_term and gpe_sum.
module geomag_poly_eval #(
    parameter int COEFF_FRAC_BITS = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [13:0] i_cfg_data,     // epoch_years
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // lon_offset [13:0], lat_offset [27:14], zeros
    input  logic [1:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // field_value
    output logic [0:0]  m_axis_tuser    // saturated
);

    localparam int VW = gpe_pkg::VAL_W;
    localparam int NS = gpe_pkg::NUM_STAGES;
    localparam int TW = gpe_pkg::MONO_W + COEFF_FRAC_BITS + gpe_pkg::COEF_INT_W;
    localparam int AW = TW + gpe_pkg::SUM_GUARD;
    localparam int OW = gpe_pkg::OUT_W;
    localparam int M0 = 1;
    localparam int T0 = M0 + gpe_pkg::MONO_STG;
    localparam int S0 = T0 + gpe_pkg::TERM_STG;
    localparam logic signed [AW-1:0] ROUND_HALF = AW'(1) <<< (COEFF_FRAC_BITS + 15);

    logic [NS-1:0]                r_vld;
    logic [NS-1:0]                w_adv;
    gpe_pkg::t_stage_en           w_en;
    logic signed [VW-1:0]         r_epoch;
    logic signed [VW-1:0]         r_x;
    logic signed [VW-1:0]         r_y;
    logic signed [VW-1:0]         r_t;
    logic [gpe_pkg::MODE_W-1:0]   r_mode;
    logic signed [gpe_pkg::MONO_W-1:0] w_mono [gpe_pkg::NUM_TERMS];
    logic [gpe_pkg::MODE_W-1:0]   w_mono_mode;
    logic signed [TW-1:0]         w_term [gpe_pkg::NUM_TERMS];
    logic signed [AW-1:0]         w_sum;
    logic signed [AW-1:0]         w_rnd;
    logic signed [AW-1:0]         w_shr;
    logic                         w_fit;
    logic [OW-1:0]                r_value;
    logic                         r_sat;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        w_adv[NS-1] = !r_vld[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign w_en.mono = w_adv[T0-1:M0];
    assign w_en.term = w_adv[S0-1:T0];
    assign w_en.sum  = w_adv[NS-2:S0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_epoch <= gpe_pkg::EPOCH_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_epoch <= i_cfg_data;
            end
            if (w_adv[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_x    <= s_axis_tdata[VW-1:0];
            r_y    <= s_axis_tdata[2*VW-1:VW];
            r_t    <= r_epoch;
            r_mode <= s_axis_tuser;
        end
    end

    gpe_mono u_mono (
        .i_clk  (i_clk),
        .i_en   (w_en.mono),
        .i_x    (r_x),
        .i_y    (r_y),
        .i_t    (r_t),
        .i_mode (r_mode),
        .o_mono (w_mono),
        .o_mode (w_mono_mode)
    );

    gpe_term #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_term (
        .i_clk  (i_clk),
        .i_en   (w_en.term),
        .i_mono (w_mono),
        .i_mode (w_mono_mode),
        .o_term (w_term)
    );

    gpe_sum #(
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_sum (
        .i_clk  (i_clk),
        .i_en   (w_en.sum),
        .i_term (w_term),
        .o_sum  (w_sum)
    );

    // Round half towards plus infinity to Q16.16, then clip to 32 bits.
    assign w_rnd = w_sum + ROUND_HALF;
    assign w_shr = w_rnd >>> (COEFF_FRAC_BITS + 16);
    assign w_fit = (&w_shr[AW-1:OW-1]) || !(|w_shr[AW-1:OW-1]);

    always_ff @(posedge i_clk) begin
        if (w_adv[NS-1]) begin
            if (w_fit) begin
                r_value <= w_shr[OW-1:0];
            end else if (w_shr[AW-1]) begin
                r_value <= gpe_pkg::OUT_NEG_MAX;
            end else begin
                r_value <= gpe_pkg::OUT_POS_MAX;
            end
            r_sat <= !w_fit;
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign s_axis_tready   = w_adv[0];
    assign m_axis_tvalid   = r_vld[NS-1];
    assign m_axis_tdata    = r_value;
    assign m_axis_tuser[0] = r_sat;

endmodule

// ===== src/gpe_mono.sv =====
// Monomial generator: powers of the three operands and the 31 scaled monomials.
// Four register stages; uses gpe_pkg for widths and exponent tables.
module gpe_mono (
    input  logic                                 i_clk,
    input  logic [gpe_pkg::MONO_STG-1:0]         i_en,
    input  logic signed [gpe_pkg::VAL_W-1:0]     i_x,
    input  logic signed [gpe_pkg::VAL_W-1:0]     i_y,
    input  logic signed [gpe_pkg::VAL_W-1:0]     i_t,
    input  logic [gpe_pkg::MODE_W-1:0]           i_mode,
    output logic signed [gpe_pkg::MONO_W-1:0]    o_mono [gpe_pkg::NUM_TERMS],
    output logic [gpe_pkg::MODE_W-1:0]           o_mode
);

    localparam int VW = gpe_pkg::VAL_W;
    localparam int PW = gpe_pkg::PWR_W;

    logic signed [VW-1:0]   r_p1 [3];
    logic signed [2*VW-1:0] r_p2 [3];
    logic signed [PW-1:0]   r_pw [3][gpe_pkg::MAX_DEG+1];
    logic signed [PW-1:0]   r_q  [gpe_pkg::NUM_TERMS];
    logic signed [PW-1:0]   r_tp [gpe_pkg::MAX_DEG+1];
    logic signed [gpe_pkg::MONO_W-1:0] r_mono [gpe_pkg::NUM_TERMS];
    logic [gpe_pkg::MODE_W-1:0] r_mode [gpe_pkg::MONO_STG];

    // Stage one: operands and squares.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p1[0]   <= i_x;
            r_p1[1]   <= i_y;
            r_p1[2]   <= i_t;
            r_p2[0]   <= i_x * i_x;
            r_p2[1]   <= i_y * i_y;
            r_p2[2]   <= i_t * i_t;
            r_mode[0] <= i_mode;
        end
    end

    // Stage two: all powers up to the fourth.
    for (genvar v = 0; v < 3; v++) begin : g_pow
        logic signed [3*VW-1:0] w_p3;
        logic signed [4*VW-1:0] w_p4;
        assign w_p3 = r_p2[v] * r_p1[v];
        assign w_p4 = r_p2[v] * r_p2[v];
        always_ff @(posedge i_clk) begin
            if (i_en[1]) begin
                r_pw[v][0] <= PW'(1);
                r_pw[v][1] <= PW'(r_p1[v]);
                r_pw[v][2] <= PW'(r_p2[v]);
                r_pw[v][3] <= PW'(w_p3);
                r_pw[v][4] <= PW'(w_p4);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_mode[1] <= r_mode[0];
        end
        if (i_en[2]) begin
            r_tp      <= r_pw[2];
            r_mode[2] <= r_mode[1];
        end
        if (i_en[3]) begin
            r_mode[3] <= r_mode[2];
        end
    end

    // Stages three and four: longitude-latitude product, then the epoch factor and scaling.
    for (genvar k = 0; k < gpe_pkg::NUM_TERMS; k++) begin : g_term
        localparam int A  = gpe_pkg::EXP_X[k];
        localparam int B  = gpe_pkg::EXP_Y[k];
        localparam int C  = gpe_pkg::EXP_T[k];
        localparam int WA = gpe_pkg::pow_w(A);
        localparam int WB = gpe_pkg::pow_w(B);
        localparam int QW = gpe_pkg::pow_w(A + B);
        localparam int WC = gpe_pkg::pow_w(C);
        localparam int SH = 8 * (gpe_pkg::MAX_DEG - (A + B + C));

        logic signed [WA+WB-1:0] w_q;
        logic signed [QW+WC-1:0] w_m;

        assign w_q = $signed(r_pw[0][A][WA-1:0]) * $signed(r_pw[1][B][WB-1:0]);
        assign w_m = $signed(r_q[k][QW-1:0]) * $signed(r_tp[C][WC-1:0]);

        always_ff @(posedge i_clk) begin
            if (i_en[2]) begin
                r_q[k] <= PW'(w_q);
            end
            if (i_en[3]) begin
                r_mono[k] <= gpe_pkg::MONO_W'(64'(w_m) <<< SH);
            end
        end
    end

    assign o_mono = r_mono;
    assign o_mode = r_mode[gpe_pkg::MONO_STG-1];

endmodule

// ===== src/gpe_term.sv =====
// Term multiplier: coefficient selection by mode and exact coefficient-by-monomial products.
// Three register stages, each product split into four partial products; uses gpe_pkg.
module gpe_term #(
    parameter int COEFF_FRAC_BITS = 40
) (
    input  logic                                  i_clk,
    input  logic [gpe_pkg::TERM_STG-1:0]          i_en,
    input  logic signed [gpe_pkg::MONO_W-1:0]     i_mono [gpe_pkg::NUM_TERMS],
    input  logic [gpe_pkg::MODE_W-1:0]            i_mode,
    output logic signed [gpe_pkg::MONO_W+COEFF_FRAC_BITS+gpe_pkg::COEF_INT_W-1:0]
                                                  o_term [gpe_pkg::NUM_TERMS]
);

    localparam int CW    = COEFF_FRAC_BITS + gpe_pkg::COEF_INT_W;
    localparam int CHI_W = CW - gpe_pkg::CLO_W;
    localparam int MLO_W = gpe_pkg::MLO_W;
    localparam int MHI_W = gpe_pkg::MONO_W - MLO_W;
    localparam int CLO_W = gpe_pkg::CLO_W;
    localparam int TW    = gpe_pkg::MONO_W + CW;

    for (genvar k = 0; k < gpe_pkg::NUM_TERMS; k++) begin : g_term
        localparam logic signed [CW-1:0] C_INT =
            CW'(gpe_pkg::coef_fixed(gpe_pkg::COEF_INT[k], COEFF_FRAC_BITS));
        localparam logic signed [CW-1:0] C_DEC =
            CW'(gpe_pkg::coef_fixed(gpe_pkg::COEF_DEC[k], COEFF_FRAC_BITS));
        localparam logic signed [CW-1:0] C_INC =
            CW'(gpe_pkg::coef_fixed(gpe_pkg::COEF_INC[k], COEFF_FRAC_BITS));

        logic signed [CW-1:0]          w_coef;
        logic signed [MLO_W:0]         w_mlo;
        logic signed [MHI_W-1:0]       w_mhi;
        logic signed [CLO_W:0]         w_clo;
        logic signed [CHI_W-1:0]       w_chi;
        logic signed [MLO_W+CLO_W+1:0] r_ll;
        logic signed [MLO_W+CHI_W:0]   r_lh;
        logic signed [MHI_W+CLO_W:0]   r_hl;
        logic signed [MHI_W+CHI_W-1:0] r_hh;
        logic signed [TW-1:0]          r_s0;
        logic signed [TW-1:0]          r_s1;
        logic signed [TW-1:0]          r_term;

        // The unused mode code selects no table, so every term and the result are zero.
        always_comb begin
            case (i_mode)
                gpe_pkg::MODE_INT: w_coef = C_INT;
                gpe_pkg::MODE_DEC: w_coef = C_DEC;
                gpe_pkg::MODE_INC: w_coef = C_INC;
                default:           w_coef = '0;
            endcase
        end

        assign w_mlo = $signed({1'b0, i_mono[k][MLO_W-1:0]});
        assign w_mhi = i_mono[k][gpe_pkg::MONO_W-1:MLO_W];
        assign w_clo = $signed({1'b0, w_coef[CLO_W-1:0]});
        assign w_chi = w_coef[CW-1:CLO_W];

        always_ff @(posedge i_clk) begin
            if (i_en[0]) begin
                r_ll <= w_mlo * w_clo;
                r_lh <= w_mlo * w_chi;
                r_hl <= w_mhi * w_clo;
                r_hh <= w_mhi * w_chi;
            end
            if (i_en[1]) begin
                r_s0 <= TW'(r_ll) + (TW'(r_lh) <<< CLO_W);
                r_s1 <= (TW'(r_hl) <<< MLO_W) + (TW'(r_hh) <<< (MLO_W + CLO_W));
            end
            if (i_en[2]) begin
                r_term <= r_s0 + r_s1;
            end
        end

        assign o_term[k] = r_term;
    end

endmodule

// ===== src/gpe_sum.sv =====
// Registered adder tree that sums the 31 exact terms over five stages.
// Uses gpe_pkg for the tree shape and term widths.
module gpe_sum #(
    parameter int COEFF_FRAC_BITS = 40
) (
    input  logic                                  i_clk,
    input  logic [gpe_pkg::TREE_DEPTH-1:0]        i_en,
    input  logic signed [gpe_pkg::MONO_W+COEFF_FRAC_BITS+gpe_pkg::COEF_INT_W-1:0]
                                                  i_term [gpe_pkg::NUM_TERMS],
    output logic signed [gpe_pkg::MONO_W+COEFF_FRAC_BITS+gpe_pkg::COEF_INT_W
                         +gpe_pkg::SUM_GUARD-1:0] o_sum
);

    localparam int TW   = gpe_pkg::MONO_W + COEFF_FRAC_BITS + gpe_pkg::COEF_INT_W;
    localparam int AW   = TW + gpe_pkg::SUM_GUARD;
    localparam int HALF = gpe_pkg::TREE_LEAVES / 2;

    // Node i has children 2i and 2i+1; nodes from HALF upwards take the terms directly.
    logic signed [AW-1:0] r_node [1:gpe_pkg::TREE_LEAVES-1];

    for (genvar i = 1; i < gpe_pkg::TREE_LEAVES; i++) begin : g_node
        localparam int DP  = $clog2(i + 1) - 1;
        localparam int STG = gpe_pkg::TREE_DEPTH - 1 - DP;
        if (i >= HALF) begin : g_leaf
            localparam int L = 2 * i - gpe_pkg::TREE_LEAVES;
            if (L + 1 < gpe_pkg::NUM_TERMS) begin : g_pair
                always_ff @(posedge i_clk) begin
                    if (i_en[STG]) begin
                        r_node[i] <= AW'(i_term[L]) + AW'(i_term[L+1]);
                    end
                end
            end else begin : g_single
                always_ff @(posedge i_clk) begin
                    if (i_en[STG]) begin
                        r_node[i] <= AW'(i_term[L]);
                    end
                end
            end
        end else begin : g_inner
            always_ff @(posedge i_clk) begin
                if (i_en[STG]) begin
                    r_node[i] <= r_node[2*i] + r_node[2*i+1];
                end
            end
        end
    end

    assign o_sum = r_node[1];

endmodule
